// ----- src/svg_pkg.sv -----
package svg_pkg;

    localparam int COEF_A = 102944;
    localparam int COEF_B = 42047;
    localparam int COEF_C = 4640;
    localparam int UNIT_Q14 = 16384;

    typedef enum logic [1:0] {
        REG_THETA_STEP = 2'd0,
        REG_PHI_STEP   = 2'd1,
        REG_RADIUS     = 2'd2
    } reg_index_t;

    // last-stage valid and the flow control shared along the pipeline
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctrl_t;

    // one signed rounded product, halves away from zero, shift by 14
    function automatic logic signed [33:0] round_q14(input logic signed [33:0] p);
        logic signed [33:0] m;
        logic [33:0] u;
        begin
            m = p[33] ? -p : p;
            u = (m + 34'sd8192) >>> 14;
            round_q14 = p[33] ? -$signed(u) : $signed(u);
        end
    endfunction

endpackage

// ----- src/svg_sine_cell.sv -----
// one pipeline cell of the polynomial sine: one angle per cell
module svg_sine_cell
    import svg_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  advance,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic signed [15:0]    sine
);

    localparam int QB = ANGLE_BITS - 2;

    logic [16:0] x_next;
    logic [16:0] x_reg, x1_reg, x2_reg, x3_reg;
    logic [1:0]  q_reg, q1_reg, q2_reg, q3_reg, q4_reg;
    logic [16:0] sq_reg, sq1_reg;
    logic [17:0] t1_reg;
    logic [17:0] t2_reg;
    logic [17:0] t3_reg;
    logic signed [15:0] m_reg;
    logic [15:0] m_mag;
    logic [QB-1:0] r;
    logic [33:0] sq_full;
    logic [35:0] c_full;
    logic [35:0] b_full;
    logic [35:0] a_full;
    logic [17:0] t3n;

    assign r = angle[QB-1:0];

    always_comb
    begin
        if (QB >= 16)
            x_next = {1'b0, 16'(r >> (QB - 16))};
        else
            x_next = {1'b0, 16'({r, 16'b0} >> QB)};
        if (angle[QB])
            x_next = 17'd65536 - x_next;
    end

    assign sq_full = x_reg * x_reg + 34'd32768;
    assign c_full  = 36'(COEF_C) * 36'(sq_reg) + 36'd32768;
    assign b_full  = 36'(t1_reg) * 36'(sq1_reg) + 36'd32768;
    assign a_full  = 36'(t2_reg) * 36'(x3_reg) + 36'd32768;
    assign t3n     = 18'((18'(a_full >> 16) + 18'd2) >> 2);
    assign m_mag   = (t3_reg > 18'(UNIT_Q14)) ? 16'(UNIT_Q14) : t3_reg[15:0];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg   <= x_next;
            q_reg   <= angle[QB+1:QB];
            sq_reg  <= 17'(sq_full >> 16);
            x1_reg  <= x_reg;
            q1_reg  <= q_reg;
            t1_reg  <= 18'(COEF_B) - 18'(c_full >> 16);
            sq1_reg <= sq_reg;
            x2_reg  <= x1_reg;
            q2_reg  <= q1_reg;
            t2_reg  <= 18'(COEF_A) - 18'(b_full >> 16);
            x3_reg  <= x2_reg;
            q3_reg  <= q2_reg;
            t3_reg  <= t3n;
            q4_reg  <= q3_reg;
            m_reg   <= q4_reg[1] ? -m_mag : m_mag;
        end
    end

    // x3_reg aligns x with t2_reg; q4 sits beside t3 so the sign goes in with the clamp
    assign sine = m_reg;

endmodule

// ----- src/svg_combine_cell.sv -----
// products of the sines into normal, binormal and position, plus the tangent
module svg_combine_cell
    import svg_pkg::*;
(
    input  logic               clk,
    input  logic               advance,
    input  logic signed [15:0] st,
    input  logic signed [15:0] ct,
    input  logic signed [15:0] sp,
    input  logic signed [15:0] cp,
    input  logic [15:0]        radius,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic signed [15:0] tangent_x,
    output logic signed [15:0] tangent_z,
    output logic signed [15:0] binormal_x,
    output logic signed [15:0] binormal_y,
    output logic signed [15:0] binormal_z
);

    logic signed [15:0] nx_reg, ny_reg, nz_reg, tx_reg, tz_reg, bx_reg, by_reg, bz_reg;
    logic signed [15:0] nx1_reg, ny1_reg, nz1_reg, tx1_reg, tz1_reg, bx1_reg, by1_reg, bz1_reg;
    logic signed [16:0] px_reg, py_reg, pz_reg;
    logic signed [16:0] rs;

    assign rs = $signed({1'b0, radius});

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            nx_reg <= 16'(round_q14(34'(st) * 34'(sp)));
            ny_reg <= -cp;
            nz_reg <= 16'(round_q14(34'(ct) * 34'(sp)));
            tx_reg <= ct;
            tz_reg <= -st;
            bx_reg <= 16'(round_q14(34'(st) * 34'(cp)));
            by_reg <= sp;
            bz_reg <= 16'(round_q14(34'(ct) * 34'(cp)));
            px_reg <= 17'(round_q14(34'(rs) * 34'(nx_reg)));
            py_reg <= 17'(round_q14(34'(rs) * 34'(ny_reg)));
            pz_reg <= 17'(round_q14(34'(rs) * 34'(nz_reg)));
            nx1_reg <= nx_reg; ny1_reg <= ny_reg; nz1_reg <= nz_reg;
            tx1_reg <= tx_reg; tz1_reg <= tz_reg;
            bx1_reg <= bx_reg; by1_reg <= by_reg; bz1_reg <= bz_reg;
        end
    end

    assign pos_x = px_reg;
    assign pos_y = py_reg;
    assign pos_z = pz_reg;
    assign normal_x = nx1_reg;
    assign normal_y = ny1_reg;
    assign normal_z = nz1_reg;
    assign tangent_x = tx1_reg;
    assign tangent_z = tz1_reg;
    assign binormal_x = bx1_reg;
    assign binormal_y = by1_reg;
    assign binormal_z = bz1_reg;

endmodule

// ----- src/sphere_vertex_generator.sv -----
// UV sphere vertex generator. Each transaction (theta_index, phi_index) yields
// one vertex: position, normal, tangent and binormal. Fully pipelined: one
// vertex per cycle while the output is not stalled, over nine register stages
// (angle multiply, six-stage sine chain, two product stages, the last of them
// the output register). A stall on the output freezes the whole chain;
// in_stall follows out_stall only when the output holds a result.
module sphere_vertex_generator
    import svg_pkg::*;
#(
    parameter int INDEX_BITS = 10,
    parameter int ANGLE_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [INDEX_BITS-1:0] theta_index,
    input  logic [INDEX_BITS-1:0] phi_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [16:0]    pos_x,
    output logic signed [16:0]    pos_y,
    output logic signed [16:0]    pos_z,
    output logic signed [15:0]    normal_x,
    output logic signed [15:0]    normal_y,
    output logic signed [15:0]    normal_z,
    output logic signed [15:0]    tangent_x,
    output logic signed [15:0]    tangent_z,
    output logic signed [15:0]    binormal_x,
    output logic signed [15:0]    binormal_y,
    output logic signed [15:0]    binormal_z,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    localparam int DEPTH = 9;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    logic [15:0] theta_step_reg, phi_step_reg, radius_reg;
    logic [DEPTH-1:0] vld_reg;
    stage_ctrl_t ctrl;
    logic [ANGLE_BITS-1:0] th_reg, ph_reg;
    logic [ANGLE_BITS-1:0] th_next, ph_next;
    logic signed [15:0] st, ct, sp, cp;

    assign ctrl.advance = !(vld_reg[DEPTH-1] && out_stall);
    assign ctrl.valid   = vld_reg[DEPTH-1];
    assign in_stall  = !ctrl.advance;
    assign out_valid = ctrl.valid;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theta_step_reg <= 16'd0;
            phi_step_reg   <= 16'd0;
            radius_reg     <= 16'd256;
            vld_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_THETA_STEP: theta_step_reg <= cfg_data;
                    REG_PHI_STEP:   phi_step_reg <= cfg_data;
                    REG_RADIUS:     radius_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (ctrl.advance)
                vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    assign th_next = ANGLE_BITS'((INDEX_BITS + 16)'(theta_index) * (INDEX_BITS + 16)'(theta_step_reg));
    assign ph_next = ANGLE_BITS'((INDEX_BITS + 16)'(phi_index) * (INDEX_BITS + 16)'(phi_step_reg));

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            th_reg <= th_next;
            ph_reg <= ph_next;
        end
    end

    svg_sine_cell #(.ANGLE_BITS(ANGLE_BITS)) u_st
        (.clk(clk), .advance(ctrl.advance), .angle(th_reg), .sine(st));
    svg_sine_cell #(.ANGLE_BITS(ANGLE_BITS)) u_ct
        (.clk(clk), .advance(ctrl.advance), .angle(th_reg + QUARTER), .sine(ct));
    svg_sine_cell #(.ANGLE_BITS(ANGLE_BITS)) u_sp
        (.clk(clk), .advance(ctrl.advance), .angle(ph_reg), .sine(sp));
    svg_sine_cell #(.ANGLE_BITS(ANGLE_BITS)) u_cp
        (.clk(clk), .advance(ctrl.advance), .angle(ph_reg + QUARTER), .sine(cp));

    svg_combine_cell u_comb
    (
        .clk(clk), .advance(ctrl.advance),
        .st(st), .ct(ct), .sp(sp), .cp(cp), .radius(radius_reg),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .tangent_x(tangent_x), .tangent_z(tangent_z),
        .binormal_x(binormal_x), .binormal_y(binormal_y), .binormal_z(binormal_z)
    );

`ifndef SYNTHESIS
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(pos_x) && $stable(normal_y))
        else $error("output changed while stalled");
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output stall");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !out_stall && !in_valid) |=> !vld_reg[0])
        else $error("valid appeared from nothing");
`endif

endmodule
